/* design/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising edge of clk, suspended while rst_n is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check prop on every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/fcd_pkg.sv */
// Shared types and constants of the fixed cell deframer.
// No dependencies; used by every module of the block.
package fcd_pkg;

  // Cell header layout
  localparam logic [15:0] HDR_LEN       = 16'd3;
  localparam logic [15:0] MIN_CELL      = 16'd4;

  // Configuration register indexes
  localparam logic [1:0]  REG_CELL_BYTES = 2'd0;
  localparam logic [1:0]  REG_DATA_TYPE  = 2'd1;
  localparam logic [1:0]  REG_DUMMY_TYPE = 2'd2;

  // Configuration reset values
  localparam logic [15:0] CELL_BYTES_RST = 16'd512;
  localparam logic [7:0]  DATA_TYPE_RST  = 8'd1;
  localparam logic [7:0]  DUMMY_TYPE_RST = 8'd0;

  // Result status codes
  localparam logic [1:0]  ST_PAYLOAD      = 2'd0;
  localparam logic [1:0]  ST_UNKNOWN_TYPE = 2'd1;
  localparam logic [1:0]  ST_BAD_LENGTH   = 2'd2;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] cell_bytes;
    logic [7:0]  data_type_code;
    logic [7:0]  dummy_type_code;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_payload;
    logic [1:0] status;
  } res_t;

endpackage

/* design/fcd_cfg.sv */
// Configuration registers of the fixed cell deframer.
// Depends on fcd_pkg.
module fcd_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output fcd_pkg::cfg_t  cfg
);

  fcd_pkg::cfg_t cfg_r;
  fcd_pkg::cfg_t cfg_nxt;

  // Decode writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fcd_pkg::REG_CELL_BYTES: cfg_nxt.cell_bytes      = cfg_wdata;
        fcd_pkg::REG_DATA_TYPE:  cfg_nxt.data_type_code  = cfg_wdata[7:0];
        fcd_pkg::REG_DUMMY_TYPE: cfg_nxt.dummy_type_code = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_bytes      <= fcd_pkg::CELL_BYTES_RST;
      cfg_r.data_type_code  <= fcd_pkg::DATA_TYPE_RST;
      cfg_r.dummy_type_code <= fcd_pkg::DUMMY_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/fcd_parser.sv */
// Input register and cell header/body parser of the fixed cell deframer.
// Depends on fcd_pkg.
module fcd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  fcd_pkg::cfg_t  cfg,
  input  logic           res_room,
  output logic           res_valid,
  output fcd_pkg::res_t  res
);

  // Parse phase codes
  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic        stg_valid_r, stg_valid_nxt;
  logic [7:0]  stg_byte_r;
  logic        advance;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic        skip_r, skip_nxt;

  logic [15:0] body;
  logic [15:0] len_full;
  logic [15:0] pos_inc;
  logic        emit;
  fcd_pkg::res_t res_c;

  // Input stage: holds one byte until the result side has room
  assign advance  = stg_valid_r && res_room;
  assign in_ready = !stg_valid_r || res_room;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end else if (advance) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte;
    end
  end

  // Body size; small cell sizes act as the minimum
  assign body = (cfg.cell_bytes < fcd_pkg::MIN_CELL) ? 16'd1
                                                      : cfg.cell_bytes - fcd_pkg::HDR_LEN;
  assign len_full = {len_r[15:8], stg_byte_r};
  assign pos_inc  = pos_r + 16'd1;

  // Per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    res_c     = '0;
    unique case (phase_r)
      PH_TYPE: begin
        kind_nxt  = stg_byte_r;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {stg_byte_r, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = len_full;
        phase_nxt = PH_BODY;
        pos_nxt   = '0;
        skip_nxt  = 1'b0;
        // dummy wins over data when both codes match
        priority if (kind_r == cfg.dummy_type_code) begin
          skip_nxt = 1'b1;
        end else if (kind_r != cfg.data_type_code) begin
          skip_nxt     = 1'b1;
          emit         = 1'b1;
          res_c.status = fcd_pkg::ST_UNKNOWN_TYPE;
        end else if (len_full == '0 || len_full > body) begin
          skip_nxt     = 1'b1;
          emit         = 1'b1;
          res_c.status = fcd_pkg::ST_BAD_LENGTH;
        end else begin
          skip_nxt = 1'b0;
        end
      end
      PH_BODY: begin
        if (!skip_r && pos_r < len_r) begin
          emit                  = 1'b1;
          res_c.payload_byte    = stg_byte_r;
          res_c.last_of_payload = (pos_inc == len_r);
          res_c.status          = fcd_pkg::ST_PAYLOAD;
        end
        pos_nxt = pos_inc;
        // end of cell, also on counter wrap
        if (pos_inc >= body || pos_inc == '0) begin
          phase_nxt = PH_TYPE;
          pos_nxt   = '0;
          kind_nxt  = '0;
          len_nxt   = '0;
          skip_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      pos_r   <= '0;
      kind_r  <= '0;
      len_r   <= '0;
      skip_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign res_valid = advance && emit;
  assign res       = res_c;

endmodule

/* design/fcd_out_buf.sv */
// Two-entry result buffer that decouples the parser from the output channel.
// Depends on fcd_pkg.
module fcd_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fcd_pkg::res_t  push_res,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output fcd_pkg::res_t  out_res
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fcd_pkg::res_t     mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r != CntW'(Depth));
  assign out_res   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

/* design/fixed_cell_deframer.sv */
// Top level of the fixed cell deframer: config registers, parser, result buffer.
// Depends on fcd_pkg, fcd_cfg, fcd_parser, fcd_out_buf and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in_     | input     | in_valid / in_ready  | in_byte
//  out_    | output    | out_valid / out_ready| out_payload_byte, out_last_of_payload, out_status
//  cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One byte per cycle sustained while the result buffer has room; a result passes through the
// input register, then the parse logic into the two-entry result buffer, from which
// out_ready can accept it.
// Reset (rst_n low, synchronous) empties both stages, restarts at a type byte and
// loads the register defaults; no clearing pass.
// When the result buffer is full the input stage holds its byte and in_ready drops,
// also in a cycle where out_ready pops an entry; bytes that give no result still wait
// for buffer room.
`include "assert_macros.svh"

module fixed_cell_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_payload,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  fcd_pkg::cfg_t cfg;
  fcd_pkg::res_t res;
  fcd_pkg::res_t out_res;
  logic          res_valid;
  logic          res_room;

  // Register file
  fcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register and parse logic
  fcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cfg       (cfg),
    .res_room  (res_room),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result buffer
  fcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .room      (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_payload_byte    = out_res.payload_byte;
  assign out_last_of_payload = out_res.last_of_payload;
  assign out_status          = out_res.status;

  // Checks
  `ASSERT_RST(a_err_zero_payload, clk, rst_n, (out_valid && out_status != fcd_pkg::ST_PAYLOAD) |-> (out_payload_byte == 8'd0 && !out_last_of_payload))
  `ASSERT_RST(a_stall_needs_backlog, clk, rst_n, !in_ready |-> out_valid)
  `ASSERT_RST(a_no_push_when_full, clk, rst_n, !res_room |-> !res_valid)
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!out_valid && in_ready))

endmodule

/* tb/testbench.sv */
// Self-checking testbench for fixed_cell_deframer: random byte streams of cells.
// Depends on fcd_pkg and the deframer RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_UNUSED   = 2'd3;   // index with no register behind it
  localparam int         SETTLE_CYCLES = 8;     // parser latency plus margin
  localparam int         PHASE_BYTES   = 330;   // least number of random bytes per config setting

  typedef enum logic [1:0] {PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_BODY} parse_phase_e;
  typedef enum int {CK_DATA, CK_DUMMY, CK_UNKNOWN, CK_BAD_LEN, CK_NOISE} cell_kind_e;

  // Scoreboard: deframes the accepted byte stream and checks each result
  class cell_scoreboard;
    fcd_pkg::cfg_t cfg;
    parse_phase_e  phase;
    logic [15:0]   pos;
    logic [7:0]    kind;
    logic [15:0]   plen;
    logic          skip;
    fcd_pkg::res_t deframed_q[$];
    int            errors;

    function new();
      cfg    = '{fcd_pkg::CELL_BYTES_RST, fcd_pkg::DATA_TYPE_RST, fcd_pkg::DUMMY_TYPE_RST};
      errors = 0;
      end_cell();
    endfunction

    function void end_cell();
      phase = PH_TYPE;
      pos   = '0;
      kind  = '0;
      plen  = '0;
      skip  = 1'b0;
    endfunction

    // Body size; anything below the minimum cell acts as a one-byte body
    function logic [15:0] body_len();
      return (cfg.cell_bytes < fcd_pkg::MIN_CELL) ? 16'd1
                                                  : cfg.cell_bytes - fcd_pkg::HDR_LEN;
    endfunction

    function void load_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        fcd_pkg::REG_CELL_BYTES: cfg.cell_bytes      = val;
        fcd_pkg::REG_DATA_TYPE:  cfg.data_type_code  = val[7:0];
        fcd_pkg::REG_DUMMY_TYPE: cfg.dummy_type_code = val[7:0];
        default: ;
      endcase
    endfunction

    // Advance the parse by one accepted byte, queueing what it produces
    function void deframe_byte(logic [7:0] b);
      logic [15:0] body;
      body = body_len();
      case (phase)
        PH_TYPE: begin
          kind  = b;
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          plen  = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          plen[7:0] = b;
          phase     = PH_BODY;
          pos       = '0;
          skip      = 1'b0;
          // dummy wins over data when the codes match; unknown type skips length check
          if (kind == cfg.dummy_type_code) begin
            skip = 1'b1;
          end else if (kind != cfg.data_type_code) begin
            skip = 1'b1;
            deframed_q.push_back('{8'h00, 1'b0, fcd_pkg::ST_UNKNOWN_TYPE});
          end else if (plen == 16'd0 || plen > body) begin
            skip = 1'b1;
            deframed_q.push_back('{8'h00, 1'b0, fcd_pkg::ST_BAD_LENGTH});
          end
        end
        default: begin
          if (!skip && pos < plen)
            deframed_q.push_back('{b, (pos + 16'd1 == plen), fcd_pkg::ST_PAYLOAD});
          pos = pos + 16'd1;
          // body size is read live, so a shrunk body ends the cell early
          if (pos >= body || pos == 16'd0) end_cell();
        end
      endcase
    endfunction

    function void compare_out(fcd_pkg::res_t got);
      fcd_pkg::res_t want;
      if (deframed_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: byte %h last %b status %0d",
                 $time, got.payload_byte, got.last_of_payload, got.status);
        return;
      end
      want = deframed_q.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        errors++;
        $display("%0t: payload_byte expected %h actual %h",
                 $time, want.payload_byte, got.payload_byte);
      end
      if (got.last_of_payload !== want.last_of_payload) begin
        errors++;
        $display("%0t: last_of_payload expected %b actual %b",
                 $time, want.last_of_payload, got.last_of_payload);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_last_of_payload;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = fcd_pkg::REG_CELL_BYTES;
  logic [15:0] cfg_wdata = 16'h0000;

  cell_scoreboard sb = new();
  int tx_gap_max = 11;
  int rx_hold_cycles = 0;
  int bytes_sent = 0;

  fixed_cell_deframer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload),
    .out_status          (out_status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one byte after a random gap; returns at the accepting edge with valid still up
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] code, input logic [15:0] len);
    send_byte(code);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop sending and wait for every expected result plus the pipeline tail
  task automatic drain();
    idle_input();
    while (sb.deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.load_reg(idx, val);
  endtask

  // One full cell of the given kind with random content
  task automatic send_cell(input cell_kind_e ck);
    logic [15:0] body;
    logic [15:0] len;
    logic [7:0]  code;
    body = sb.body_len();
    len  = 16'($urandom_range(0, 16'hFFFF));
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
    case (ck)
      CK_DATA: begin
        code = sb.cfg.data_type_code;
        len  = ($urandom_range(0, 3) == 0) ? body : 16'($urandom_range(1, body));
      end
      CK_DUMMY: code = sb.cfg.dummy_type_code;
      CK_UNKNOWN: begin
        do code = 8'($urandom_range(0, 255));
        while (code == sb.cfg.data_type_code || code == sb.cfg.dummy_type_code);
      end
      CK_BAD_LEN: begin
        code = sb.cfg.data_type_code;
        if ($urandom_range(0, 1) == 0 || body == 16'hFFFF) len = 16'd0;
        else len = 16'($urandom_range(body + 1, 16'hFFFF));
      end
      default: code = 8'($urandom_range(0, 255));
    endcase
    send_header(code, len);
    repeat (body) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls, calm stretches, and long hold-offs on request
  initial begin : result_sink
    int  stall;
    bit  rx_calm;
    rx_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.compare_out('{out_payload_byte, out_last_of_payload, out_status});
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
    end
  end

  // Stimulus
  initial begin : main_seq
    fcd_pkg::cfg_t plan [6];
    int            r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one of each cell kind on one-byte bodies with reset type codes
    write_reg(fcd_pkg::REG_CELL_BYTES, 16'd4);
    send_header(fcd_pkg::DATA_TYPE_RST, 16'd1);
    send_byte(8'hFF);
    send_header(fcd_pkg::DUMMY_TYPE_RST, 16'hFFFF);
    send_byte(8'h00);
    send_header(8'h80, 16'd0);
    send_byte(8'h55);
    send_header(fcd_pkg::DATA_TYPE_RST, 16'd0);
    send_byte(8'hAA);
    send_header(fcd_pkg::DATA_TYPE_RST, 16'd2);
    send_byte(8'h01);
    drain();

    // Unused index is ignored; equal type codes make the cell a dummy
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(fcd_pkg::REG_DATA_TYPE, 16'd7);
    write_reg(fcd_pkg::REG_DUMMY_TYPE, 16'd7);
    send_header(8'h07, 16'd1);
    send_byte(8'h3C);
    drain();

    // Largest cell: bad length just over the body, then shrink the size mid-body; again with the longest good length
    write_reg(fcd_pkg::REG_DUMMY_TYPE, 16'd0);
    write_reg(fcd_pkg::REG_CELL_BYTES, 16'hFFFF);
    send_header(8'h07, 16'd65533);
    send_byte(8'h11);
    send_byte(8'h22);
    drain();
    write_reg(fcd_pkg::REG_CELL_BYTES, 16'd3);
    send_byte(8'h33);
    drain();
    write_reg(fcd_pkg::REG_CELL_BYTES, 16'hFFFF);
    send_header(8'h07, 16'd65532);
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    drain();
    write_reg(fcd_pkg::REG_CELL_BYTES, 16'd0);
    send_byte(8'h44);
    drain();

    // Random part: several settings, mostly well-formed data cells
    plan[0] = '{16'd4, 8'h00, 8'hFF};
    plan[1] = '{16'd5, 8'hFF, 8'h00};
    plan[2] = '{16'($urandom_range(6, 40)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255))};
    plan[3] = '{16'($urandom_range(64, 160)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255))};
    plan[4] = '{16'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    plan[5] = '{16'($urandom_range(6, 24)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255))};
    foreach (plan[p]) begin
      write_reg(fcd_pkg::REG_CELL_BYTES, plan[p].cell_bytes);
      write_reg(fcd_pkg::REG_DATA_TYPE, 16'(plan[p].data_type_code));
      write_reg(fcd_pkg::REG_DUMMY_TYPE, 16'(plan[p].dummy_type_code));
      bytes_sent = 0;
      // receiver holds off a long while so the block backs up into the input
      if (p == 1) rx_hold_cycles = 300;
      while (bytes_sent < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r <= 5)      send_cell(CK_DATA);
        else if (r == 6) send_cell(CK_DUMMY);
        else if (r == 7) send_cell(CK_UNKNOWN);
        else if (r == 8) send_cell(CK_BAD_LEN);
        else             send_cell(CK_NOISE);
      end
      drain();
    end

    if (sb.errors == 0 && sb.deframed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
